// ===== rtl/fptf_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fptf_pkg
// Shared types and codes for the FIFO with promote-to-front.
// ----------------------------------------------------------------------------
package fptf_pkg;

  localparam int KEY_PORT_W = 16;
  localparam int STATUS_W   = 2;
  localparam int OCC_W      = 5;
  localparam int OP_W       = 2;

  // operation codes, same encoding as the mode port
  localparam logic [OP_W-1:0] OP_PUSH    = 2'd0;
  localparam logic [OP_W-1:0] OP_POP     = 2'd1;
  localparam logic [OP_W-1:0] OP_PROMOTE = 2'd2;
  localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

  // result status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY    = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL     = 2'd2;
  localparam logic [STATUS_W-1:0] ST_NOTFOUND = 2'd3;

  // command queue between front and back
  localparam int CMDQ_DEPTH = 2;
  localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
  localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  typedef struct packed {
    logic [OP_W-1:0]       op;
    logic [KEY_PORT_W-1:0] key;
  } cmd_t;

endpackage

// ===== rtl/fptf_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fptf_front
// Accepts operations, masks the key and holds them in a short command queue.
// ----------------------------------------------------------------------------
module fptf_front #(
  parameter int KEY_WIDTH = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fptf_pkg::OP_W-1:0]       mode,
  input  logic [fptf_pkg::KEY_PORT_W-1:0] item_key,
  output logic                           cmd_valid,
  input  logic                           cmd_ready,
  output fptf_pkg::cmd_t                 cmd
);
  import fptf_pkg::*;

  localparam int KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam logic [KEY_PORT_W-1:0] KEY_MASK = {KEY_PORT_W{1'b1}} >> (KEY_PORT_W - KW);

  cmd_t                  slots [CMDQ_DEPTH];
  logic [CMDQ_PTR_W-1:0] wr_ptr;
  logic [CMDQ_PTR_W-1:0] rd_ptr;
  logic [CMDQ_CNT_W-1:0] fill;
  cmd_t                  new_cmd;
  logic                  push;
  logic                  pop;

  assign in_ready  = (fill != CMDQ_CNT_W'(CMDQ_DEPTH));
  assign cmd_valid = (fill != '0);
  assign cmd       = slots[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = cmd_valid && cmd_ready;

  always_comb begin
    new_cmd.op  = mode;
    new_cmd.key = item_key & KEY_MASK;
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= new_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == CMDQ_PTR_W'(CMDQ_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, pop})
        2'b10:   fill <= fill + 1'b1;
        2'b01:   fill <= fill - 1'b1;
        default: fill <= fill;
      endcase
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CMDQ_CNT_W'(CMDQ_DEPTH))
    else $error("command queue overfilled");

endmodule

// ===== rtl/fptf_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fptf_back
// Key cell array: parallel compare and shift, one operation per cycle when not stalled.
// ----------------------------------------------------------------------------
module fptf_back #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cmd_valid,
  output logic                           cmd_ready,
  input  fptf_pkg::cmd_t                 cmd,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fptf_pkg::STATUS_W-1:0]   status,
  output logic [fptf_pkg::KEY_PORT_W-1:0] head_key,
  output logic [fptf_pkg::OCC_W-1:0]      occupancy
);
  import fptf_pkg::*;

  localparam int KW = (KEY_WIDTH < KEY_PORT_W) ? KEY_WIDTH : KEY_PORT_W;
  localparam int CW = $clog2(QUEUE_DEPTH + 1);

  logic [KW-1:0]          entry_keys [QUEUE_DEPTH];
  logic [CW-1:0]          count;
  logic [CW-1:0]          count_next;
  logic [QUEUE_DEPTH-1:0] match;
  logic [QUEUE_DEPTH:0]   seen;
  logic [KW-1:0]          ck;
  logic                   fire;
  logic                   full;
  logic                   empty;
  logic                   found;
  logic [STATUS_W-1:0]    status_next;

  assign ck        = cmd.key[KW-1:0];
  assign cmd_ready = !out_valid || out_ready;
  assign fire      = cmd_valid && cmd_ready;
  assign full      = (count == CW'(QUEUE_DEPTH));
  assign empty     = (count == '0);

  // seen[i]: some entry ahead of cell i matches
  assign seen[0] = 1'b0;
  assign found   = seen[QUEUE_DEPTH];

  for (genvar i = 0; i < QUEUE_DEPTH; i++) begin : g_cell
    assign match[i]  = (CW'(i) < count) && (entry_keys[i] == ck);
    assign seen[i+1] = seen[i] | match[i];

    always_ff @(posedge clk) begin
      if (fire) begin
        case (cmd.op)
          OP_PUSH: begin
            if (!full && count == CW'(i)) begin
              entry_keys[i] <= ck;
            end
          end
          OP_POP: begin
            if (i < QUEUE_DEPTH - 1 && !empty) begin
              entry_keys[i] <= entry_keys[(i < QUEUE_DEPTH - 1) ? i + 1 : i];
            end
          end
          OP_PROMOTE: begin
            // cells up to the first match shift back by one, the key lands at the head
            if (found && !seen[i]) begin
              entry_keys[i] <= (i == 0) ? ck : entry_keys[(i > 0) ? i - 1 : 0];
            end
          end
          default: ;
        endcase
      end
    end
  end

  always_comb begin
    status_next = ST_OK;
    count_next  = count;
    unique case (cmd.op)
      OP_PUSH: begin
        if (full) status_next = ST_FULL;
        else      count_next  = count + 1'b1;
      end
      OP_POP: begin
        if (empty) status_next = ST_EMPTY;
        else       count_next  = count - 1'b1;
      end
      OP_PROMOTE: begin
        if (!found) status_next = ST_NOTFOUND;
      end
      OP_NOP: ;
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (fire) begin
        count <= count_next;
      end
      if (fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      status    <= status_next;
      head_key  <= (cmd.op == OP_POP && !empty) ? KEY_PORT_W'(entry_keys[0]) : '0;
      occupancy <= OCC_W'(count_next);
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(QUEUE_DEPTH))
    else $error("entry count beyond depth");

  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.op == OP_POP && empty |=> out_valid && status == ST_EMPTY && head_key == '0)
    else $error("pop on empty queue misreported");

  a_push_grows: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.op == OP_PUSH && !full |=> count == $past(count) + 1'b1)
    else $error("push did not grow the queue");

  a_promote_head: assert property (@(posedge clk) disable iff (rst)
    fire && cmd.op == OP_PROMOTE && found |=> entry_keys[0] == $past(ck))
    else $error("promoted key not at head");

endmodule

// ===== rtl/fifo_with_promote_to_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fifo_with_promote_to_front
// Ordered key FIFO with push, pop and promote-to-head of the first match.
// ----------------------------------------------------------------------------
// path: an accepted transaction passes the command queue, then the cell array and
//   result register, to its result
// throughput: one transaction per cycle while out_ready allows, set by the compare
//   and shift across all key cells at once
// reset: empties the queue and drops pending results; stored keys are not cleared
module fifo_with_promote_to_front #(
  parameter int QUEUE_DEPTH = 16,
  parameter int KEY_WIDTH   = 16
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [fptf_pkg::OP_W-1:0]       mode,
  input  logic [fptf_pkg::KEY_PORT_W-1:0] item_key,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [fptf_pkg::STATUS_W-1:0]   status,
  output logic [fptf_pkg::KEY_PORT_W-1:0] head_key,
  output logic [fptf_pkg::OCC_W-1:0]      occupancy
);
  import fptf_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_ready;

  fptf_front #(
    .KEY_WIDTH (KEY_WIDTH)
  ) u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .mode      (mode),
    .item_key  (item_key),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd)
  );

  fptf_back #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .KEY_WIDTH   (KEY_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (cmd_valid),
    .cmd_ready (cmd_ready),
    .cmd       (cmd),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .status    (status),
    .head_key  (head_key),
    .occupancy (occupancy)
  );

endmodule

// ===== sim/tb_fifo_with_promote_to_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_fifo_with_promote_to_front
// Self-checking bench for the key FIFO with push, pop and promote-to-head.
// A driver feeds transactions from a backlog, a shadow queue predicts each
// result on acceptance, and a monitor compares every result field by field.
// Runs a directed opening, then weighted random bursts under three idling
// phases, with one long receiver hold-off to back the block up.
// ----------------------------------------------------------------------------
module tb_fifo_with_promote_to_front;
  import fptf_pkg::*;

  localparam int Q_DEPTH = 16;
  localparam int K_WIDTH = 16;
  localparam int HOLD_CYCLES = 80;
  localparam int RANDOM_PER_PHASE = 415;

  typedef struct {
    logic [OP_W-1:0]       op;
    logic [KEY_PORT_W-1:0] key;
  } queue_op_t;

  typedef struct {
    logic [STATUS_W-1:0]   status;
    logic [KEY_PORT_W-1:0] head;
    logic [OCC_W-1:0]      occ;
  } queue_result_t;

  typedef enum int {
    MIX_FILL,
    MIX_BALANCED,
    MIX_DRAIN
  } op_mix_t;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  in_valid = 1'b0;
  logic                  in_ready;
  logic [OP_W-1:0]       mode = OP_PUSH;
  logic [KEY_PORT_W-1:0] item_key = '0;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  logic [STATUS_W-1:0]   status;
  logic [KEY_PORT_W-1:0] head_key;
  logic [OCC_W-1:0]      occupancy;

  queue_op_t     op_backlog[$];
  queue_result_t pending_results[$];

  // shadow of the key queue, index 0 is the head
  logic [KEY_PORT_W-1:0] shadow_keys [Q_DEPTH];
  int                    shadow_count = 0;

  logic [KEY_PORT_W-1:0] key_pool [8];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int hold_req = 0;
  int hold_ack = 0;
  int hold_left = 0;
  int mismatch_count = 0;

  fifo_with_promote_to_front #(
    .QUEUE_DEPTH(Q_DEPTH),
    .KEY_WIDTH  (K_WIDTH)
  ) u_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .mode     (mode),
    .item_key (item_key),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .status   (status),
    .head_key (head_key),
    .occupancy(occupancy)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #400000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic queue_result_t apply_queue_op(logic [OP_W-1:0] op,
                                                   logic [KEY_PORT_W-1:0] key);
    queue_result_t         r;
    int                    pos;
    logic [KEY_PORT_W-1:0] moved;
    r.status = ST_OK;
    r.head   = '0;
    pos      = -1;
    case (op)
      OP_PUSH: begin
        if (shadow_count >= Q_DEPTH) begin
          r.status = ST_FULL;
        end else begin
          shadow_keys[shadow_count] = key;
          shadow_count++;
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          r.status = ST_EMPTY;
        end else begin
          r.head = shadow_keys[0];
          for (int i = 1; i < shadow_count; i++) shadow_keys[i-1] = shadow_keys[i];
          shadow_count--;
        end
      end
      OP_PROMOTE: begin
        for (int i = 0; i < shadow_count; i++) begin
          if (pos < 0 && shadow_keys[i] == key) pos = i;
        end
        if (pos < 0) begin
          r.status = ST_NOTFOUND;
        end else begin
          moved = shadow_keys[pos];
          for (int i = pos; i > 0; i--) shadow_keys[i] = shadow_keys[i-1];
          shadow_keys[0] = moved;
        end
      end
      default: ;
    endcase
    r.occ = shadow_count[OCC_W-1:0];
    return r;
  endfunction

  // driver: predict on acceptance, then present the next transaction if the slot is free
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) pending_results.push_back(apply_queue_op(mode, item_key));
      if (!in_valid || in_ready) begin
        if (op_backlog.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          mode     <= op_backlog[0].op;
          item_key <= op_backlog[0].key;
          void'(op_backlog.pop_front());
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor: check results, drive out_ready, run the long hold-off on request
  always @(posedge clk) begin
    queue_result_t exp_r;
    if (rst) begin
      out_ready <= 1'b0;
      hold_left <= 0;
      hold_ack  <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: status %0d head_key %0h occupancy %0d",
                 status, head_key, occupancy);
          mismatch_count++;
        end else begin
          exp_r = pending_results.pop_front();
          if (status !== exp_r.status) begin
            $error("status: expected %0d, got %0d", exp_r.status, status);
            mismatch_count++;
          end
          if (head_key !== exp_r.head) begin
            $error("head_key: expected %0h, got %0h", exp_r.head, head_key);
            mismatch_count++;
          end
          if (occupancy !== exp_r.occ) begin
            $error("occupancy: expected %0d, got %0d", exp_r.occ, occupancy);
            mismatch_count++;
          end
        end
      end
      if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        out_ready <= 1'b0;
      end else if (hold_req != hold_ack) begin
        hold_ack  <= hold_req;
        hold_left <= HOLD_CYCLES;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic add_op(logic [OP_W-1:0] op, logic [KEY_PORT_W-1:0] key);
    queue_op_t t;
    t.op  = op;
    t.key = key;
    op_backlog.push_back(t);
  endtask

  // mostly keys from a small pool so promotes hit and duplicates pile up
  function automatic logic [KEY_PORT_W-1:0] pick_key();
    if ($urandom_range(3) != 0) return key_pool[$urandom_range(7)];
    return KEY_PORT_W'($urandom);
  endfunction

  task automatic add_random_burst(op_mix_t mix, int n);
    int w_push;
    int w_pop;
    int w_prom;
    int roll;
    case (mix)
      MIX_FILL:     begin w_push = 60; w_pop = 15; w_prom = 20; end
      MIX_BALANCED: begin w_push = 35; w_pop = 30; w_prom = 30; end
      default:      begin w_push = 15; w_pop = 55; w_prom = 25; end
    endcase
    for (int i = 0; i < n; i++) begin
      roll = $urandom_range(99);
      if (roll < w_push) add_op(OP_PUSH, pick_key());
      else if (roll < w_push + w_pop) add_op(OP_POP, KEY_PORT_W'($urandom));
      else if (roll < w_push + w_pop + w_prom) add_op(OP_PROMOTE, pick_key());
      else add_op(OP_NOP, KEY_PORT_W'($urandom));
    end
  endtask

  task automatic add_random_phase(int n);
    int left;
    int len;
    left = n;
    while (left > 0) begin
      len = $urandom_range(20, 60);
      if (len > left) len = left;
      add_random_burst(op_mix_t'($urandom_range(2)), len);
      left -= len;
    end
  endtask

  task automatic wait_until_drained();
    do @(negedge clk);
    while (op_backlog.size() != 0 || in_valid || pending_results.size() != 0);
  endtask

  initial begin
    for (int i = 0; i < 8; i++) key_pool[i] = KEY_PORT_W'($urandom);
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: empty cases, extremes, head and mid promotes, duplicates, full
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    add_op(OP_POP, 16'hFFFF);
    add_op(OP_PROMOTE, 16'h0000);
    add_op(OP_NOP, 16'hA5A5);
    add_op(OP_PUSH, 16'h0000);
    add_op(OP_PUSH, 16'hFFFF);
    add_op(OP_PUSH, 16'h1234);
    add_op(OP_PUSH, 16'h0000);
    add_op(OP_PROMOTE, 16'h0000);
    add_op(OP_PROMOTE, 16'h1234);
    add_op(OP_PROMOTE, 16'h0000);
    add_op(OP_PROMOTE, 16'hABCD);
    for (int i = 0; i < Q_DEPTH - 4; i++) add_op(OP_PUSH, KEY_PORT_W'(16'h1111 * (i + 1)));
    add_op(OP_PUSH, 16'h5A5A);
    add_op(OP_PROMOTE, 16'hCCCC);
    add_op(OP_POP, 16'h0000);
    wait_until_drained();

    send_idle_pct <= 36;
    recv_idle_pct <= 62;
    add_random_phase(RANDOM_PER_PHASE);
    wait_until_drained();

    send_idle_pct <= 62;
    recv_idle_pct <= 36;
    add_random_phase(RANDOM_PER_PHASE);
    wait_until_drained();

    // no idling; the receiver holds off long while the sender keeps offering
    send_idle_pct <= 0;
    recv_idle_pct <= 0;
    add_random_phase(RANDOM_PER_PHASE);
    hold_req <= hold_req + 1;
    wait_until_drained();

    repeat (8) @(negedge clk);
    if (pending_results.size() != 0) begin
      $error("%0d results never arrived", pending_results.size());
    end
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
